FILE: rtl/core/rfs_pkg.sv
// Shared constants, types and helpers of the read flag statistics block.
package rfs_pkg;

  localparam int unsigned INSERT_BINS = 65536;
  localparam int unsigned MAPQ_BINS   = 256;
  localparam int unsigned COUNT_WIDTH = 48;
  localparam int unsigned READ_W      = 48;

  localparam int unsigned INS_AW   = $clog2(INSERT_BINS);
  localparam int unsigned MQ_IDX_W = $clog2(MAPQ_BINS);
  localparam int unsigned MQ_AW    = MQ_IDX_W + 1;
  localparam int unsigned MQ_DEPTH = 2 * MAPQ_BINS;

  localparam int unsigned NUM_CLASS = 11;
  localparam int unsigned NUM_CNT   = 2 * NUM_CLASS + 1;
  localparam int unsigned OVF_IDX   = 2 * NUM_CLASS;
  localparam int unsigned CNT_IDX_W = $clog2(NUM_CNT);

  localparam int unsigned CLR_LEN = (INSERT_BINS > MQ_DEPTH) ? INSERT_BINS : MQ_DEPTH;
  localparam int unsigned CLR_W   = $clog2(CLR_LEN);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned OBUF_DEPTH = 3;
  localparam int unsigned OPTR_W     = $clog2(OBUF_DEPTH);
  localparam int unsigned OCNT_W     = $clog2(OBUF_DEPTH + 1);

  localparam logic [7:0] THRESH_RESET = 8'd5;

  // Flag bit positions.
  localparam int unsigned F_PAIRED = 0;
  localparam int unsigned F_PROPER = 1;
  localparam int unsigned F_UNMAP  = 2;
  localparam int unsigned F_MUNMAP = 3;
  localparam int unsigned F_READ1  = 6;
  localparam int unsigned F_READ2  = 7;
  localparam int unsigned F_QCFAIL = 9;
  localparam int unsigned F_DUP    = 10;

  // Event classes.
  localparam int unsigned CLS_READS     = 0;
  localparam int unsigned CLS_PAIRED    = 1;
  localparam int unsigned CLS_PROPER    = 2;
  localparam int unsigned CLS_READ1     = 3;
  localparam int unsigned CLS_READ2     = 4;
  localparam int unsigned CLS_SINGLETON = 5;
  localparam int unsigned CLS_BOTH      = 6;
  localparam int unsigned CLS_DIFF_REF  = 7;
  localparam int unsigned CLS_DIFF_HQ   = 8;
  localparam int unsigned CLS_MAPPED    = 9;
  localparam int unsigned CLS_DUP       = 10;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BANK_EVENT    = 2'd0,
    BANK_INSERT   = 2'd1,
    BANK_MQ_R1    = 2'd2,
    BANK_MQ_OTHER = 2'd3
  } bank_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic                 is_read;
    logic [NUM_CNT-1:0]   ev_mask;
    logic                 ins_inc;
    logic [INS_AW-1:0]    ins_addr;
    logic                 mq_inc;
    logic [MQ_AW-1:0]     mq_addr;
    bank_e                rd_bank;
    logic [CNT_IDX_W-1:0] cnt_idx;
    logic                 rd_bad;
  } rfs_op_t;

  typedef struct packed {
    logic [READ_W-1:0] read_value;
    logic              bad_index;
  } rfs_res_t;

  function automatic count_t sat_inc(count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

endpackage

FILE: rtl/core/rfs_in_if.sv
// Input channel carrying one record or readout request per transaction.
interface rfs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [15:0]        flag;
  logic signed [31:0] insert_size;
  logic signed [31:0] ref_id;
  logic signed [31:0] mate_ref_id;
  logic [7:0]         map_quality;
  logic [1:0]         read_bank;
  logic [15:0]        read_index;

  modport source (
    output valid, kind, flag, insert_size, ref_id, mate_ref_id, map_quality,
           read_bank, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, flag, insert_size, ref_id, mate_ref_id, map_quality,
           read_bank, read_index,
    output ready
  );
endinterface

FILE: rtl/core/rfs_out_if.sv
// Output channel carrying one readout result per transaction.
interface rfs_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] read_value;
  logic        bad_index;

  modport source (output valid, read_value, bad_index, input ready);
  modport sink (input valid, read_value, bad_index, output ready);
endinterface

FILE: rtl/core/read_flag_statistics.sv
// Top level of the read flag statistics block.
//
//   Channel   Direction  Contents
//   in_i      sink       count record or readout request (kind selects)
//   out_o     source     read_value, bad_index for each readout request
//   cfg       write      diff_ref_quality_threshold (cfg_we_i, cfg_wdata_i)
//
// One transaction per cycle is accepted while the operation queue is not full; a
// histogram bin updated by consecutive records is carried through a write bypass on each
// memory. A readout result passes the operation queue, the stage-one register and the
// result buffer on its way to out_o. After reset a clearing pass holds in_i.ready low.
// A stalled out_o fills a three-entry result buffer; then readouts wait in the
// four-entry operation queue, and records behind them wait too, keeping order.
module read_flag_statistics import rfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  rfs_in_if.sink     in_i,
  rfs_out_if.source  out_o
);

  logic    push;
  rfs_op_t push_op;
  logic    pop;
  rfs_op_t head;
  logic    q_empty;
  logic    q_full;
  logic    clearing;

  rfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .push_o      (push),
    .op_o        (push_op)
  );

  rfs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  rfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule

FILE: rtl/core/rfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rfs_front.sv
// Front end: accepts input transactions and decodes them into counter operations.
module rfs_front import rfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  rfs_in_if.sink     in_i,
  input  logic       q_full_i,
  input  logic       clearing_i,
  output logic       push_o,
  output rfs_op_t    op_o
);

  logic [7:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = ~q_full_i & ~clearing_i;
  assign push_o     = in_i.valid & in_i.ready;

  logic [15:0]          flag;
  logic                 qcf;
  logic                 mapped;
  logic                 mate_mapped;
  logic                 paired;
  logic                 both;
  logic                 diff_ref;
  logic [NUM_CLASS-1:0] hit;
  logic [31:0]          isz;
  logic [31:0]          mag;
  logic                 ins_hit;
  logic                 ins_ovf;
  logic [31:0]          idx32;
  bank_e                bank;
  rfs_op_t              cnt_op;
  rfs_op_t              rd_op;

  always_comb begin
    flag        = in_i.flag;
    qcf         = flag[F_QCFAIL];
    mapped      = ~flag[F_UNMAP];
    mate_mapped = ~flag[F_MUNMAP];
    paired      = flag[F_PAIRED];
    both        = paired & mapped & mate_mapped;
    diff_ref    = in_i.ref_id != in_i.mate_ref_id;

    hit                = '0;
    hit[CLS_READS]     = 1'b1;
    hit[CLS_PAIRED]    = paired;
    hit[CLS_PROPER]    = paired & flag[F_PROPER];
    hit[CLS_READ1]     = paired & flag[F_READ1];
    hit[CLS_READ2]     = paired & flag[F_READ2];
    hit[CLS_SINGLETON] = paired & mapped & ~mate_mapped;
    hit[CLS_BOTH]      = both;
    hit[CLS_DIFF_REF]  = both & diff_ref;
    hit[CLS_DIFF_HQ]   = both & diff_ref & (in_i.map_quality >= thresh_q);
    hit[CLS_MAPPED]    = mapped;
    hit[CLS_DUP]       = flag[F_DUP];

    // The most negative size negates to itself, which as unsigned is 2^31.
    isz     = in_i.insert_size;
    mag     = isz[31] ? (~isz + 32'd1) : isz;
    ins_hit = both & (isz != 32'd0);
    ins_ovf = ins_hit & (mag >= INSERT_BINS);

    cnt_op         = '0;
    cnt_op.is_read = 1'b0;
    for (int k = 0; k < NUM_CLASS; k++) begin
      cnt_op.ev_mask[2*k]   = hit[k] & ~qcf;
      cnt_op.ev_mask[2*k+1] = hit[k] & qcf;
    end
    cnt_op.ev_mask[OVF_IDX] = ins_ovf;
    cnt_op.ins_inc          = ins_hit & ~ins_ovf;
    cnt_op.ins_addr         = INS_AW'(mag);
    cnt_op.mq_inc           = mapped;
    cnt_op.mq_addr          = {~flag[F_READ1], MQ_IDX_W'(in_i.map_quality)};
    cnt_op.rd_bank          = BANK_EVENT;

    idx32 = 32'(in_i.read_index);
    bank  = bank_e'(in_i.read_bank);

    rd_op          = '0;
    rd_op.is_read  = 1'b1;
    rd_op.ins_addr = INS_AW'(idx32);
    rd_op.mq_addr  = {bank == BANK_MQ_OTHER, MQ_IDX_W'(idx32)};
    rd_op.rd_bank  = bank;
    rd_op.cnt_idx  = CNT_IDX_W'(idx32);
    case (bank)
      BANK_EVENT:  rd_op.rd_bad = idx32 > OVF_IDX;
      BANK_INSERT: rd_op.rd_bad = idx32 >= INSERT_BINS;
      default:     rd_op.rd_bad = idx32 >= MAPQ_BINS;
    endcase

    op_o = (in_i.kind == KIND_READ) ? rd_op : cnt_op;
  end

endmodule

FILE: rtl/core/rfs_queue.sv
// Short FIFO of decoded operations between the front and back ends.
module rfs_queue import rfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  rfs_op_t push_op_i,
  input  logic    pop_i,
  output rfs_op_t head_o,
  output logic    empty_o,
  output logic    full_o
);

  rfs_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= next_ptr(rptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && push_i))
    else $error("operation queue written while full");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(empty_o && pop_i))
    else $error("operation queue read while empty");

endmodule

FILE: rtl/core/rfs_back.sv
// Back end: event counters, histogram read-modify-write and result buffer.
module rfs_back import rfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  rfs_op_t head_i,
  output logic    pop_o,
  output logic    clearing_o,
  rfs_out_if.source out_o
);

  // Clearing pass over both histogram memories after reset.
  logic             clearing_q;
  logic [CLR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (32'(clr_q) == CLR_LEN - 1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign clearing_o = clearing_q;

  // Issue and stage one.
  logic              s1_valid_q;
  rfs_op_t           s1_op_q;
  logic              s1_rd;
  logic              s1_cnt;
  logic [OCNT_W-1:0] out_cnt_q;
  logic [OCNT_W:0]   pend;
  logic              room;

  assign s1_rd  = s1_valid_q & s1_op_q.is_read;
  assign s1_cnt = s1_valid_q & ~s1_op_q.is_read;

  // A readout issues only if the result buffer has space for every result in flight.
  assign pend  = {1'b0, out_cnt_q} + {{OCNT_W{1'b0}}, s1_rd};
  assign room  = pend < (OCNT_W + 1)'(OBUF_DEPTH);
  assign pop_o = ~clearing_q & ~q_empty_i & (~head_i.is_read | room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_op_q <= head_i;
    end
  end

  // Insert-size histogram.
  count_t            ins_rdata;
  count_t            ins_cur;
  count_t            ins_wdata;
  logic [INS_AW-1:0] ins_waddr;
  logic              ins_we;
  logic              ins_upd;
  logic              ins_lw_v_q;
  logic [INS_AW-1:0] ins_lw_a_q;
  count_t            ins_lw_d_q;

  rfs_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (INSERT_BINS)
  ) u_ins_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (ins_waddr),
    .wdata_i (ins_wdata),
    .raddr_i (head_i.ins_addr),
    .rdata_o (ins_rdata)
  );

  // The write of the previous cycle is not yet in the read data; take it from the bypass.
  assign ins_cur   = (ins_lw_v_q && ins_lw_a_q == s1_op_q.ins_addr) ? ins_lw_d_q : ins_rdata;
  assign ins_upd   = s1_cnt & s1_op_q.ins_inc;
  assign ins_we    = clearing_q ? (32'(clr_q) < INSERT_BINS) : ins_upd;
  assign ins_waddr = clearing_q ? clr_q[INS_AW-1:0] : s1_op_q.ins_addr;
  assign ins_wdata = clearing_q ? '0 : sat_inc(ins_cur);

  // Mapping-quality histograms share one memory, the upper address bit selects read1 or other.
  count_t           mq_rdata;
  count_t           mq_cur;
  count_t           mq_wdata;
  logic [MQ_AW-1:0] mq_waddr;
  logic             mq_we;
  logic             mq_upd;
  logic             mq_lw_v_q;
  logic [MQ_AW-1:0] mq_lw_a_q;
  count_t           mq_lw_d_q;

  rfs_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MQ_DEPTH)
  ) u_mq_ram (
    .clk_i   (clk_i),
    .we_i    (mq_we),
    .waddr_i (mq_waddr),
    .wdata_i (mq_wdata),
    .raddr_i (head_i.mq_addr),
    .rdata_o (mq_rdata)
  );

  assign mq_cur   = (mq_lw_v_q && mq_lw_a_q == s1_op_q.mq_addr) ? mq_lw_d_q : mq_rdata;
  assign mq_upd   = s1_cnt & s1_op_q.mq_inc;
  assign mq_we    = clearing_q ? (32'(clr_q) < MQ_DEPTH) : mq_upd;
  assign mq_waddr = clearing_q ? clr_q[MQ_AW-1:0] : s1_op_q.mq_addr;
  assign mq_wdata = clearing_q ? '0 : sat_inc(mq_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_lw_v_q <= 1'b0;
      mq_lw_v_q  <= 1'b0;
    end else begin
      ins_lw_v_q <= ins_upd;
      mq_lw_v_q  <= mq_upd;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_lw_a_q <= s1_op_q.ins_addr;
    ins_lw_d_q <= ins_wdata;
    mq_lw_a_q  <= s1_op_q.mq_addr;
    mq_lw_d_q  <= mq_wdata;
  end

  // Event counters, with the insert overflow counter in the last slot.
  count_t cnt_q [NUM_CNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (s1_cnt) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (s1_op_q.ev_mask[i]) begin
          cnt_q[i] <= sat_inc(cnt_q[i]);
        end
      end
    end
  end

  // Readout result.
  count_t      rd_val;
  logic [63:0] rd_wide;
  rfs_res_t    res;

  always_comb begin
    rd_val = '0;
    case (s1_op_q.rd_bank)
      BANK_EVENT: begin
        if (32'(s1_op_q.cnt_idx) < NUM_CNT) begin
          rd_val = cnt_q[s1_op_q.cnt_idx];
        end
      end
      BANK_INSERT: rd_val = ins_cur;
      default:     rd_val = mq_cur;
    endcase
    if (s1_op_q.rd_bad) begin
      rd_val = '0;
    end
    rd_wide        = 64'(rd_val);
    res.read_value = rd_wide[READ_W-1:0];
    res.bad_index  = s1_op_q.rd_bad;
  end

  // Result buffer.
  rfs_res_t          obuf_q [OBUF_DEPTH];
  logic [OPTR_W-1:0] owr_q;
  logic [OPTR_W-1:0] ord_q;
  logic              out_pop;

  function automatic logic [OPTR_W-1:0] next_optr(logic [OPTR_W-1:0] p);
    return (p == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_pop = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (s1_rd) begin
      obuf_q[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q     <= '0;
      ord_q     <= '0;
      out_cnt_q <= '0;
    end else begin
      if (s1_rd) begin
        owr_q <= next_optr(owr_q);
      end
      if (out_pop) begin
        ord_q <= next_optr(ord_q);
      end
      case ({s1_rd, out_pop})
        2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
        2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
        default: out_cnt_q <= out_cnt_q;
      endcase
    end
  end

  assign out_o.valid      = out_cnt_q != '0;
  assign out_o.read_value = obuf_q[ord_q].read_value;
  assign out_o.bad_index  = obuf_q[ord_q].bad_index;

  a_buf_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_rd |-> (out_cnt_q != OCNT_W'(OBUF_DEPTH)))
    else $error("readout result arrives at a full result buffer");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!pop_o && !s1_valid_q))
    else $error("operation in flight during the clearing pass");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_index) |-> (out_o.read_value == '0))
    else $error("out-of-range readout carries a nonzero value");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> (32'($past(clr_q)) == CLR_LEN - 1))
    else $error("clearing pass ended before covering every entry");

endmodule

FILE: verif/read_flag_statistics_tb.sv
// Self-checking testbench for the read flag statistics block: directed, random and stall tests.
module read_flag_statistics_tb;
  import rfs_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    kind_e              kind;
    logic [15:0]        flag;
    logic signed [31:0] insert_size;
    logic signed [31:0] ref_id;
    logic signed [31:0] mate_ref_id;
    logic [7:0]         map_quality;
    bank_e              read_bank;
    logic [15:0]        read_index;
  } stat_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  rfs_in_if  in_i ();
  rfs_out_if out_o ();

  read_flag_statistics DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .out_o      (out_o)
  );

  // Predicted contents of every store of the block.
  count_t     event_count [NUM_CNT];
  count_t     insert_count [int unsigned];
  count_t     mapq_r1_count [MAPQ_BINS];
  count_t     mapq_other_count [MAPQ_BINS];
  logic [7:0] hq_threshold;
  rfs_res_t   expected_reads [$];

  int send_idle     = 1;
  int recv_idle     = 1;
  int hold_left     = 0;
  int error_total   = 0;
  int record_total  = 0;
  int readout_total = 0;
  int cfg_total     = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous bound on the whole run, including the clearing pass after reset.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic count_t inc_sat(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void bump_event(int unsigned cls, logic fail_bit);
    event_count[2 * cls + fail_bit] = inc_sat(event_count[2 * cls + fail_bit]);
  endfunction

  function automatic count_t insert_bin(int unsigned idx);
    return insert_count.exists(idx) ? insert_count[idx] : '0;
  endfunction

  function automatic void tally_record(stat_item_t it);
    logic   fail_bit;
    logic   mapped;
    logic   mate_mapped;
    longint mag;
    fail_bit    = it.flag[F_QCFAIL];
    mapped      = !it.flag[F_UNMAP];
    mate_mapped = !it.flag[F_MUNMAP];
    bump_event(CLS_READS, fail_bit);
    if (it.flag[F_PAIRED]) begin
      bump_event(CLS_PAIRED, fail_bit);
      if (it.flag[F_PROPER]) bump_event(CLS_PROPER, fail_bit);
      if (it.flag[F_READ1]) bump_event(CLS_READ1, fail_bit);
      if (it.flag[F_READ2]) bump_event(CLS_READ2, fail_bit);
      if (mapped && !mate_mapped) bump_event(CLS_SINGLETON, fail_bit);
      if (mapped && mate_mapped) begin
        if (it.insert_size != 0) begin
          mag = it.insert_size;
          if (mag < 0) mag = -mag;
          if (mag < longint'(INSERT_BINS)) begin
            insert_count[int'(mag)] = inc_sat(insert_bin(int'(mag)));
          end else begin
            event_count[OVF_IDX] = inc_sat(event_count[OVF_IDX]);
          end
        end
        bump_event(CLS_BOTH, fail_bit);
        if (it.ref_id != it.mate_ref_id) begin
          bump_event(CLS_DIFF_REF, fail_bit);
          if (it.map_quality >= hq_threshold) bump_event(CLS_DIFF_HQ, fail_bit);
        end
      end
    end
    if (mapped) begin
      bump_event(CLS_MAPPED, fail_bit);
      if (it.flag[F_READ1]) begin
        mapq_r1_count[it.map_quality] = inc_sat(mapq_r1_count[it.map_quality]);
      end else begin
        mapq_other_count[it.map_quality] = inc_sat(mapq_other_count[it.map_quality]);
      end
    end
    if (it.flag[F_DUP]) bump_event(CLS_DUP, fail_bit);
  endfunction

  function automatic rfs_res_t lookup_stat(stat_item_t it);
    rfs_res_t res;
    res = '0;
    case (it.read_bank)
      BANK_EVENT: begin
        if (it.read_index <= OVF_IDX) res.read_value = event_count[it.read_index];
        else res.bad_index = 1'b1;
      end
      BANK_INSERT: begin
        if (it.read_index < INSERT_BINS) res.read_value = insert_bin(it.read_index);
        else res.bad_index = 1'b1;
      end
      BANK_MQ_R1: begin
        if (it.read_index < MAPQ_BINS) res.read_value = mapq_r1_count[it.read_index[7:0]];
        else res.bad_index = 1'b1;
      end
      default: begin
        if (it.read_index < MAPQ_BINS) res.read_value = mapq_other_count[it.read_index[7:0]];
        else res.bad_index = 1'b1;
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stat_item_t count_item(logic [15:0] flag, int isz, int rid, int mrid,
                                            int q);
    stat_item_t it;
    it.kind        = KIND_COUNT;
    it.flag        = flag;
    it.insert_size = isz;
    it.ref_id      = rid;
    it.mate_ref_id = mrid;
    it.map_quality = q[7:0];
    it.read_bank   = bank_e'($urandom_range(0, 3));
    it.read_index  = 16'($urandom());
    return it;
  endfunction

  function automatic stat_item_t readout_item(bank_e bank, int unsigned idx);
    stat_item_t it;
    it             = count_item(16'($urandom()), $urandom(), $urandom(), $urandom(),
                                $urandom());
    it.kind        = KIND_READ;
    it.read_bank   = bank;
    it.read_index  = idx[15:0];
    return it;
  endfunction

  function automatic logic [15:0] pair_flag(bit proper, bit unmap, bit munmap, bit r1, bit r2,
                                            bit qcfail, bit dup);
    logic [15:0] f;
    f           = '0;
    f[F_PAIRED] = 1'b1;
    f[F_PROPER] = proper;
    f[F_UNMAP]  = unmap;
    f[F_MUNMAP] = munmap;
    f[F_READ1]  = r1;
    f[F_READ2]  = r2;
    f[F_QCFAIL] = qcfail;
    f[F_DUP]    = dup;
    return f;
  endfunction

  // Mostly well-formed paired records with small inserts and few references, so that
  // bins and counters repeat; the rest is raw noise and readouts.
  function automatic stat_item_t random_item();
    int          r;
    int          sel;
    int          isz;
    int          idx;
    bit          r1;
    bank_e       bank;
    logic [15:0] f;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      bank = bank_e'($urandom_range(0, 3));
      sel  = $urandom_range(0, 9);
      if (sel == 0) idx = $urandom_range(0, 65535);
      else if (bank == BANK_EVENT) idx = $urandom_range(0, OVF_IDX + 1);
      else if (bank == BANK_INSERT) idx = $urandom_range(0, 700);
      else idx = $urandom_range(0, MAPQ_BINS + 4);
      return readout_item(bank, idx);
    end
    if (r < 42) begin
      return count_item(16'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    end
    r1 = 1'($urandom_range(0, 1));
    f  = pair_flag(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 7) == 0, r1, !r1, $urandom_range(0, 7) == 0,
                   $urandom_range(0, 5) == 0);
    f[F_PAIRED] = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 9);
    if (sel == 0) isz = 0;
    else if (sel == 1) isz = $urandom();
    else if (sel == 2) isz = $urandom_range(INSERT_BINS - 6, INSERT_BINS + 4);
    else isz = $urandom_range(1, 600);
    if (sel >= 2 && $urandom_range(0, 1)) isz = -isz;
    return count_item(f, isz, $urandom_range(0, 2),
                      ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, 2),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 255));
  endfunction

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_item(stat_item_t it);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_i.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_i.kind        <= it.kind;
    in_i.flag        <= it.flag;
    in_i.insert_size <= it.insert_size;
    in_i.ref_id      <= it.ref_id;
    in_i.mate_ref_id <= it.mate_ref_id;
    in_i.map_quality <= it.map_quality;
    in_i.read_bank   <= it.read_bank;
    in_i.read_index  <= it.read_index;
    in_i.valid       <= 1'b1;
    do @(posedge clk_i); while (in_i.ready !== 1'b1);
    if (it.kind == KIND_READ) begin
      expected_reads.push_back(lookup_stat(it));
      readout_total++;
    end else begin
      tally_record(it);
      record_total++;
    end
  endtask

  // Records give no result, so a drain wait after the last result lets the last of them retire.
  task automatic wait_quiet();
    in_i.valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    hq_threshold = value;
    cfg_we_i    <= 1'b0;
    cfg_total++;
  endtask

  // Receiver: checks each result transaction and stalls at random.
  initial begin
    int       stall_left;
    logic     next_ready;
    rfs_res_t want;
    stall_left = 0;
    out_o.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_o.valid === 1'b1 && out_o.ready === 1'b1) begin
        if (expected_reads.size() == 0) begin
          $error("readout result with none outstanding: read_value %0h bad_index %0b",
                 out_o.read_value, out_o.bad_index);
          error_total++;
        end else begin
          want = expected_reads.pop_front();
          if (out_o.read_value !== want.read_value) begin
            $error("read_value: expected %0h, actual %0h", want.read_value, out_o.read_value);
            error_total++;
          end
          if (out_o.bad_index !== want.bad_index) begin
            $error("bad_index: expected %0b, actual %0b", want.bad_index, out_o.bad_index);
            error_total++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        stall_left = pick_gap();
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_o.ready <= next_ready;
    end
  end

  task automatic test_directed();
    send_item(count_item(16'hFFFF, 32'sh7FFFFFFF, -1, 32'sh7FFFFFFF, 255));
    send_item(count_item(16'h0000, 0, 0, 0, 0));
    send_item(count_item(pair_flag(1, 0, 0, 1, 0, 0, 0), 5, 0, 0, 60));
    send_item(count_item(pair_flag(1, 0, 0, 0, 1, 0, 0), -5, 0, 0, 60));
    send_item(count_item(pair_flag(0, 0, 0, 1, 0, 0, 0), 0, 1, 1, 7));
    // The most negative insert size has no positive twin and lands in overflow.
    send_item(count_item(pair_flag(0, 0, 0, 0, 1, 0, 0), 32'sh80000000, 2, 2, 30));
    send_item(count_item(pair_flag(1, 0, 0, 1, 0, 0, 0), INSERT_BINS - 1, 0, 0, 255));
    send_item(count_item(pair_flag(0, 0, 0, 1, 0, 1, 0), -INSERT_BINS, 3, -1, 255));
    send_item(count_item(pair_flag(0, 0, 0, 0, 1, 0, 1), 100, 4, 5, THRESH_RESET - 1));
    send_item(count_item(pair_flag(0, 0, 0, 1, 0, 0, 0), 100, 32'sh7FFFFFFF, -1,
                         THRESH_RESET));
    send_item(count_item(pair_flag(0, 0, 1, 1, 0, 0, 0), 50, 0, 0, 20));
    send_item(count_item(pair_flag(0, 1, 0, 0, 1, 1, 1), 50, 0, 1, 20));
    send_item(readout_item(BANK_EVENT, OVF_IDX));
    send_item(readout_item(BANK_EVENT, OVF_IDX + 1));
    send_item(readout_item(BANK_EVENT, 16'hFFFF));
    send_item(readout_item(BANK_EVENT, 2 * CLS_DIFF_HQ));
    send_item(readout_item(BANK_EVENT, 2 * CLS_DIFF_HQ + 1));
    send_item(readout_item(BANK_INSERT, 0));
    send_item(readout_item(BANK_INSERT, 5));
    send_item(readout_item(BANK_INSERT, INSERT_BINS - 1));
    send_item(readout_item(BANK_MQ_R1, MAPQ_BINS - 1));
    send_item(readout_item(BANK_MQ_R1, MAPQ_BINS));
    send_item(readout_item(BANK_MQ_OTHER, 0));
    send_item(readout_item(BANK_MQ_OTHER, 16'hFFFF));
    wait_quiet();
  endtask

  // Back-to-back records on the same bins exercise the write bypass.
  task automatic test_same_bin_burst();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 16; i++) begin
      send_item(count_item(pair_flag(1, 0, 0, 1'(i % 2), !(i % 2), 0, 0),
                           (i % 4 < 2) ? 77 : -78, 0, i % 3, 42));
    end
    send_item(readout_item(BANK_INSERT, 77));
    send_item(readout_item(BANK_INSERT, 78));
    send_item(readout_item(BANK_MQ_R1, 42));
    send_item(readout_item(BANK_MQ_OTHER, 42));
    send_item(readout_item(BANK_EVENT, 2 * CLS_DIFF_REF));
    wait_quiet();
    send_idle = 1;
    recv_idle = 1;
  endtask

  task automatic test_random(logic [7:0] threshold, int count, int idle);
    write_threshold(threshold);
    send_idle = idle;
    recv_idle = idle;
    repeat (count) send_item(random_item());
    wait_quiet();
    send_idle = 1;
    recv_idle = 1;
  endtask

  // The receiver holds off long enough for the result buffer and the operation
  // queue to fill, so the input has to stall.
  task automatic test_backpressure();
    send_idle = 0;
    hold_left = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_item(random_item());
      else send_item(readout_item(BANK_EVENT, $urandom_range(0, OVF_IDX)));
    end
    wait_quiet();
    send_idle = 1;
  endtask

  task automatic test_final_dump();
    for (int i = 0; i <= OVF_IDX; i++) send_item(readout_item(BANK_EVENT, i));
    for (int i = 0; i < MAPQ_BINS; i++) begin
      send_item(readout_item(BANK_MQ_R1, i));
      send_item(readout_item(BANK_MQ_OTHER, i));
    end
    for (int i = 0; i <= 300; i++) send_item(readout_item(BANK_INSERT, i));
    for (int i = INSERT_BINS - 8; i < INSERT_BINS; i++) send_item(readout_item(BANK_INSERT, i));
    wait_quiet();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_i.valid       <= 1'b0;
    in_i.kind        <= KIND_COUNT;
    in_i.flag        <= '0;
    in_i.insert_size <= '0;
    in_i.ref_id      <= '0;
    in_i.mate_ref_id <= '0;
    in_i.map_quality <= '0;
    in_i.read_bank   <= BANK_EVENT;
    in_i.read_index  <= '0;
    hq_threshold = THRESH_RESET;
    for (int i = 0; i < NUM_CNT; i++) event_count[i] = '0;
    for (int i = 0; i < MAPQ_BINS; i++) begin
      mapq_r1_count[i]    = '0;
      mapq_other_count[i] = '0;
    end
    insert_count.delete();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_same_bin_burst();
    test_random(8'd0, 300, 1);
    test_random(8'd255, 300, 0);
    test_random(8'($urandom_range(1, 254)), 300, 1);
    test_random(THRESH_RESET, 300, 1);
    test_backpressure();
    test_final_dump();

    $display("Covered %0d records and %0d readouts under %0d threshold settings,",
             record_total, readout_total, cfg_total + 1);
    $display("with random idling on both channels and one long output stall.");
    if (error_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
